>>> sv/e2cm_pkg.sv
// Shared constants, types and fixed-point helpers for the Euler-to-camera matrix unit.
// No dependencies; imported by e2cm_sincos, euler_to_camera_matrix_unit and the testbench.
package e2cm_pkg;

  // Field widths and formats
  localparam int ANGLE_BITS = 16;
  localparam int FRAC_BITS  = 14;
  localparam int ANG_W      = 16;
  localparam int POS_W      = 32;
  localparam int OUT_W      = 16;

  // Q2.30 working format
  localparam logic [30:0] Q30_ONE  = 31'h4000_0000;
  localparam logic [29:0] Q30_HALF = 30'h2000_0000;

  // 2*pi in Q30 scaled by 2^32 is 6746518852 = 2^32 + TWO_PI_LO
  localparam logic [31:0] TWO_PI_LO = 32'd2451551556;

  // Horner series: cosine has six steps, sine five (its last slot is a plain delay)
  localparam int HORNER_STEPS = 6;
  localparam int SIN_STEPS    = 5;

  localparam logic [7:0] SIN_DIV [HORNER_STEPS] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6, 8'd1};
  localparam logic [7:0] COS_DIV [HORNER_STEPS] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};

  // floor(2^32 / d), quotient estimate is exact or one low
  localparam logic [31:0] SIN_RCP [HORNER_STEPS] = '{
    32'((64'd1 << 32) / 110), 32'((64'd1 << 32) / 72), 32'((64'd1 << 32) / 42),
    32'((64'd1 << 32) / 20),  32'((64'd1 << 32) / 6),  32'hFFFF_FFFF};
  localparam logic [31:0] COS_RCP [HORNER_STEPS] = '{
    32'((64'd1 << 32) / 132), 32'((64'd1 << 32) / 90), 32'((64'd1 << 32) / 56),
    32'((64'd1 << 32) / 30),  32'((64'd1 << 32) / 12), 32'((64'd1 << 32) / 2)};

  // Pipeline depths
  localparam int SC_LAT   = 3 + 3 * HORNER_STEPS + 2;
  localparam int TOP_LAT  = SC_LAT + 4;

  // Context that travels along the Horner chain
  typedef struct packed {
    logic [29:0] th;
    logic [29:0] z;
    logic [1:0]  quad;
    logic        swap;
  } sc_ctx_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } pos_t;

  // Rounded Q30 product of nonnegative values
  function automatic logic [30:0] qmul(input logic [30:0] a, input logic [30:0] b);
    logic [61:0] p;
    p = 62'(a) * 62'(b) + 62'(Q30_HALF);
    return p[60:30];
  endfunction

  // Quotient estimate n * floor(2^32/d) >> 32
  function automatic logic [30:0] recip_est(input logic [30:0] n, input logic [31:0] rcp);
    logic [62:0] p;
    p = 63'(n) * 63'(rcp);
    return p[62:32];
  endfunction

  // Correct the estimate by one and form ONE - quotient
  function automatic logic [30:0] horner_k(input logic [30:0] n, input logic [30:0] q0,
                                           input logic [7:0] d);
    logic [38:0] qd;
    logic [30:0] r;
    logic [30:0] qf;
    qd = 39'(q0) * 39'(d);
    r  = n - qd[30:0];
    qf = (r >= 31'(d)) ? q0 + 31'd1 : q0;
    return Q30_ONE - qf;
  endfunction

  // Signed Q30 product, rounding half away from zero
  function automatic logic signed [31:0] smul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic        neg;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [30:0] m;
    neg = a[31] ^ b[31];
    ma  = a[31] ? 32'(-a) : 32'(a);
    mb  = b[31] ? 32'(-b) : 32'(b);
    m   = qmul(ma[30:0], mb[30:0]);
    return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  // Q30 to Q1.FRAC_BITS, round half away from zero, clamp to +/- 1.0
  function automatic logic [OUT_W-1:0] to_out(input logic signed [32:0] v);
    localparam int SHIFT = 30 - FRAC_BITS;
    localparam logic [33:0] RND = (SHIFT > 0) ? (34'd1 << (SHIFT - 1)) : 34'd0;
    localparam logic [33:0] LIM = 34'd1 << FRAC_BITS;
    logic [33:0] m;
    m = v[32] ? 34'(-v) : 34'(v);
    m = (m + RND) >> SHIFT;
    if (m > LIM) begin
      m = LIM;
    end
    if (v[32]) begin
      m = 34'd0 - m;
    end
    return m[OUT_W-1:0];
  endfunction

endpackage

>>> sv/e2cm_sincos.sv
// Pipelined sine/cosine of a turn-fraction angle in signed Q30.
// Depends on e2cm_pkg (qmul, Horner divisor tables, context type).
module e2cm_sincos (
  input  logic                         clk,
  input  logic                         en,
  input  logic [e2cm_pkg::ANG_W-1:0]   ang,
  output logic signed [31:0]           sin_o,
  output logic signed [31:0]           cos_o
);
  import e2cm_pkg::*;

  localparam int CTX_N = 3 * HORNER_STEPS + 1;

  // Reduction stage
  logic [1:0]  quad_r;
  logic        swap_r;
  logic [29:0] x_r;
  logic [31:0] turn;
  logic [29:0] frac;
  logic        swap_nxt;

  assign turn     = {ang[ANGLE_BITS-1:0], (32 - ANGLE_BITS)'(0)};
  assign frac     = turn[29:0];
  assign swap_nxt = frac > Q30_HALF;

  always_ff @(posedge clk) begin
    if (en) begin
      quad_r <= turn[31:30];
      swap_r <= swap_nxt;
      x_r    <= swap_nxt ? 30'(Q30_ONE - 31'(frac)) : frac;
    end
  end

  // Angle to radians: th = x + ((x * TWO_PI_LO + 2^31) >> 32)
  logic [29:0] th_r;
  logic [1:0]  quad1_r;
  logic        swap1_r;
  logic [62:0] thp;

  assign thp = 63'(x_r) * 63'(TWO_PI_LO) + (63'd1 << 31);

  always_ff @(posedge clk) begin
    if (en) begin
      th_r    <= 30'(31'(x_r) + thp[62:32]);
      quad1_r <= quad_r;
      swap1_r <= swap_r;
    end
  end

  // Square, then the Horner chains
  sc_ctx_t     ctx_r [CTX_N];
  logic [30:0] z_full;

  assign z_full = qmul({1'b0, th_r}, {1'b0, th_r});

  logic [30:0] cn_a_r [HORNER_STEPS];
  logic [30:0] cn_b_r [HORNER_STEPS];
  logic [30:0] cq_b_r [HORNER_STEPS];
  logic [30:0] ck_r   [HORNER_STEPS];
  logic [30:0] sn_a_r [HORNER_STEPS];
  logic [30:0] sn_b_r [HORNER_STEPS];
  logic [30:0] sq_b_r [HORNER_STEPS];
  logic [30:0] sk_r   [HORNER_STEPS];
  logic [30:0] ck_in  [HORNER_STEPS];
  logic [30:0] sk_in  [HORNER_STEPS];

  always_comb begin
    ck_in[0] = Q30_ONE;
    sk_in[0] = Q30_ONE;
    for (int i = 1; i < HORNER_STEPS; i++) begin
      ck_in[i] = ck_r[i-1];
      sk_in[i] = sk_r[i-1];
    end
  end

  // Each step: rounded product, reciprocal estimate, correction
  always_ff @(posedge clk) begin
    if (en) begin
      ctx_r[0] <= '{th: th_r, z: z_full[29:0], quad: quad1_r, swap: swap1_r};
      for (int j = 1; j < CTX_N; j++) begin
        ctx_r[j] <= ctx_r[j-1];
      end
      for (int i = 0; i < HORNER_STEPS; i++) begin
        cn_a_r[i] <= qmul({1'b0, ctx_r[3*i].z}, ck_in[i]) + 31'(COS_DIV[i] >> 1);
        cn_b_r[i] <= cn_a_r[i];
        cq_b_r[i] <= recip_est(cn_a_r[i], COS_RCP[i]);
        ck_r[i]   <= horner_k(cn_b_r[i], cq_b_r[i], COS_DIV[i]);
        if (i < SIN_STEPS) begin
          sn_a_r[i] <= qmul({1'b0, ctx_r[3*i].z}, sk_in[i]) + 31'(SIN_DIV[i] >> 1);
          sn_b_r[i] <= sn_a_r[i];
          sq_b_r[i] <= recip_est(sn_a_r[i], SIN_RCP[i]);
          sk_r[i]   <= horner_k(sn_b_r[i], sq_b_r[i], SIN_DIV[i]);
        end else begin
          // sine series is done; keep it aligned with cosine
          sn_a_r[i] <= sk_in[i];
          sn_b_r[i] <= sn_a_r[i];
          sq_b_r[i] <= '0;
          sk_r[i]   <= sn_b_r[i];
        end
      end
    end
  end

  // Final sine product
  logic [30:0] fs_r;
  logic [30:0] fc_r;
  logic [1:0]  fquad_r;
  logic        fswap_r;

  always_ff @(posedge clk) begin
    if (en) begin
      fs_r    <= qmul({1'b0, ctx_r[CTX_N-1].th}, sk_r[HORNER_STEPS-1]);
      fc_r    <= ck_r[HORNER_STEPS-1];
      fquad_r <= ctx_r[CTX_N-1].quad;
      fswap_r <= ctx_r[CTX_N-1].swap;
    end
  end

  // Octant swap and quadrant map
  logic signed [31:0] s0;
  logic signed [31:0] c0;
  logic signed [31:0] sin_nxt;
  logic signed [31:0] cos_nxt;
  logic signed [31:0] sin_r;
  logic signed [31:0] cos_r;

  always_comb begin
    s0 = $signed({1'b0, fswap_r ? fc_r : fs_r});
    c0 = $signed({1'b0, fswap_r ? fs_r : fc_r});
    unique case (fquad_r)
      2'd0: begin sin_nxt = s0;  cos_nxt = c0;  end
      2'd1: begin sin_nxt = c0;  cos_nxt = -s0; end
      2'd2: begin sin_nxt = -s0; cos_nxt = -c0; end
      default: begin sin_nxt = -c0; cos_nxt = s0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_r <= sin_nxt;
      cos_r <= cos_nxt;
    end
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

>>> sv/euler_to_camera_matrix_unit.sv
// Top level: Y-X-Z Euler angles and position to a camera-to-world matrix.
// Depends on e2cm_pkg and e2cm_sincos.
//
//  channel | ports                             | handshake
//  --------+-----------------------------------+----------------------
//  input   | in_angle_x/y/z, in_pos_x/y/z      | in_valid / in_ready
//  output  | out_u_*, out_v_*, out_w_*, out_t_* | out_valid / out_ready
//
// One transaction per cycle while the output is not stalled; an item passes
// through the sine/cosine pipelines (a six-step Horner chain at three stages
// per step), then pair products, triple products, sums and rounding.
// Reset clears only the valid bits. A stalled output freezes the whole
// pipeline; in_ready drops only while a finished result is held.
module euler_to_camera_matrix_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [e2cm_pkg::ANG_W-1:0]         in_angle_x,
  input  logic [e2cm_pkg::ANG_W-1:0]         in_angle_y,
  input  logic [e2cm_pkg::ANG_W-1:0]         in_angle_z,
  input  logic signed [e2cm_pkg::POS_W-1:0]  in_pos_x,
  input  logic signed [e2cm_pkg::POS_W-1:0]  in_pos_y,
  input  logic signed [e2cm_pkg::POS_W-1:0]  in_pos_z,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [e2cm_pkg::OUT_W-1:0]  out_u_x,
  output logic signed [e2cm_pkg::OUT_W-1:0]  out_u_y,
  output logic signed [e2cm_pkg::OUT_W-1:0]  out_u_z,
  output logic signed [e2cm_pkg::OUT_W-1:0]  out_v_x,
  output logic signed [e2cm_pkg::OUT_W-1:0]  out_v_y,
  output logic signed [e2cm_pkg::OUT_W-1:0]  out_v_z,
  output logic signed [e2cm_pkg::OUT_W-1:0]  out_w_x,
  output logic signed [e2cm_pkg::OUT_W-1:0]  out_w_y,
  output logic signed [e2cm_pkg::OUT_W-1:0]  out_w_z,
  output logic signed [e2cm_pkg::POS_W-1:0]  out_t_x,
  output logic signed [e2cm_pkg::POS_W-1:0]  out_t_y,
  output logic signed [e2cm_pkg::POS_W-1:0]  out_t_z
);
  import e2cm_pkg::*;

  // Pipeline advance: move unless a held result is not taken
  logic                en;
  logic [TOP_LAT-1:0]  vld_r;

  assign en       = !vld_r[TOP_LAT-1] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[TOP_LAT-2:0], in_valid};
    end
  end

  // Position rides along with the item
  pos_t tp_r [TOP_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      tp_r[0] <= '{x: in_pos_x, y: in_pos_y, z: in_pos_z};
      for (int j = 1; j < TOP_LAT; j++) begin
        tp_r[j] <= tp_r[j-1];
      end
    end
  end

  // Sine/cosine: 1 = yaw (y), 2 = pitch (x), 3 = roll (z)
  logic signed [31:0] s1, c1, s2, c2, s3, c3;

  e2cm_sincos u_sc_y (.clk(clk), .en(en), .ang(in_angle_y), .sin_o(s1), .cos_o(c1));
  e2cm_sincos u_sc_x (.clk(clk), .en(en), .ang(in_angle_x), .sin_o(s2), .cos_o(c2));
  e2cm_sincos u_sc_z (.clk(clk), .en(en), .ang(in_angle_z), .sin_o(s3), .cos_o(c3));

  // Pair products
  logic signed [31:0] c1c3_r, s1s2_r, c2s3_r, c1s2_r, c3s1_r, c2c3_r;
  logic signed [31:0] c2s1_r, c1c2_r, s1s3_r, c1s3_r, ns2_r, s2_r, s3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      c1c3_r <= smul(c1, c3);
      s1s2_r <= smul(s1, s2);
      c2s3_r <= smul(c2, s3);
      c1s2_r <= smul(c1, s2);
      c3s1_r <= smul(c3, s1);
      c2c3_r <= smul(c2, c3);
      c2s1_r <= smul(c2, s1);
      c1c2_r <= smul(c1, c2);
      s1s3_r <= smul(s1, s3);
      c1s3_r <= smul(c1, s3);
      ns2_r  <= -s2;
      s2_r   <= s2;
      s3_r   <= s3;
    end
  end

  // Triple products, left to right
  logic signed [31:0] s1s2s3_r, c1s2s3_r, c3s1s2_r, c1c3s2_r;
  logic signed [31:0] p_c1c3_r, p_c2s3_r, p_c3s1_r, p_c1s3_r, p_c2c3_r, p_s1s3_r;
  logic signed [31:0] p_c2s1_r, p_ns2_r, p_c1c2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s1s2s3_r <= smul(s1s2_r, s3_r);
      c1s2s3_r <= smul(c1s2_r, s3_r);
      c3s1s2_r <= smul(c3s1_r, s2_r);
      c1c3s2_r <= smul(c1c3_r, s2_r);
      p_c1c3_r <= c1c3_r;
      p_c2s3_r <= c2s3_r;
      p_c3s1_r <= c3s1_r;
      p_c1s3_r <= c1s3_r;
      p_c2c3_r <= c2c3_r;
      p_s1s3_r <= s1s3_r;
      p_c2s1_r <= c2s1_r;
      p_ns2_r  <= ns2_r;
      p_c1c2_r <= c1c2_r;
    end
  end

  // Sums and differences in Q30
  logic signed [32:0] sum_r [9];

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r[0] <= 33'(p_c1c3_r) + 33'(s1s2s3_r);
      sum_r[1] <= 33'(p_c2s3_r);
      sum_r[2] <= 33'(c1s2s3_r) - 33'(p_c3s1_r);
      sum_r[3] <= 33'(c3s1s2_r) - 33'(p_c1s3_r);
      sum_r[4] <= 33'(p_c2c3_r);
      sum_r[5] <= 33'(c1c3s2_r) + 33'(p_s1s3_r);
      sum_r[6] <= 33'(p_c2s1_r);
      sum_r[7] <= 33'(p_ns2_r);
      sum_r[8] <= 33'(p_c1c2_r);
    end
  end

  // Rounding and clamp into the output register
  logic [OUT_W-1:0] m_r [9];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int e = 0; e < 9; e++) begin
        m_r[e] <= to_out(sum_r[e]);
      end
    end
  end

  assign out_valid = vld_r[TOP_LAT-1];
  assign out_u_x   = $signed(m_r[0]);
  assign out_u_y   = $signed(m_r[1]);
  assign out_u_z   = $signed(m_r[2]);
  assign out_v_x   = $signed(m_r[3]);
  assign out_v_y   = $signed(m_r[4]);
  assign out_v_z   = $signed(m_r[5]);
  assign out_w_x   = $signed(m_r[6]);
  assign out_w_y   = $signed(m_r[7]);
  assign out_w_z   = $signed(m_r[8]);
  assign out_t_x   = tp_r[TOP_LAT-1].x;
  assign out_t_y   = tp_r[TOP_LAT-1].y;
  assign out_t_z   = tp_r[TOP_LAT-1].z;

  // Checks
  localparam logic signed [OUT_W-1:0] LIM = OUT_W'(1 << FRAC_BITS);

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input accepted while the output is stalled");

  a_frozen_valids: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("valid bits moved during a stall");

  a_entry_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_u_x <= LIM && out_u_x >= -LIM && out_v_y <= LIM &&
                   out_v_y >= -LIM && out_w_z <= LIM && out_w_z >= -LIM))
    else $error("matrix entry beyond +/- 1.0");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

endmodule

>>> verif/euler_to_camera_matrix_unit_test.sv
// Testbench for euler_to_camera_matrix_unit: directed and random angle/position
// transactions checked against an in-bench fixed-point predictor. Needs e2cm_pkg and the RTL.
`timescale 1ns / 1ps

module euler_to_camera_matrix_unit_test;
  import e2cm_pkg::*;

  typedef struct packed {
    logic [15:0] ux, uy, uz, vx, vy, vz, wx, wy, wz;
    logic [31:0] tx, ty, tz;
  } matrix_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] in_angle_x = '0, in_angle_y = '0, in_angle_z = '0;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic signed [15:0] out_u_x, out_u_y, out_u_z, out_v_x, out_v_y, out_v_z;
  logic signed [15:0] out_w_x, out_w_y, out_w_z;
  logic signed [31:0] out_t_x, out_t_y, out_t_z;

  matrix_t matrix_queue[$];
  int      mismatch_count = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;

  euler_to_camera_matrix_unit u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Fixed-point helpers for the predictor
  function automatic longint unsigned fx_mul(longint unsigned a, longint unsigned b);
    return (a * b + 64'h2000_0000) >> 30;
  endfunction

  function automatic longint fx_smul(longint a, longint b);
    longint unsigned m;
    m = fx_mul((a < 0) ? -a : a, (b < 0) ? -b : b);
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic void turn_sin_cos(logic [15:0] ang, output longint s_o, output longint c_o);
    longint unsigned sdiv[5] = '{110, 72, 42, 20, 6};
    longint unsigned cdiv[6] = '{132, 90, 56, 30, 12, 2};
    longint unsigned t, f, x, th, z, k;
    logic [1:0] q;
    bit swp;
    longint s, c, tmp;
    t = longint'(ang) << 16;
    q = t[31:30];
    f = t & 64'h3FFF_FFFF;
    swp = f > 64'h2000_0000;
    x = swp ? (64'h4000_0000 - f) : f;
    th = (x * 64'd6746518852 + 64'h8000_0000) >> 32;
    z = fx_mul(th, th);
    k = 64'h4000_0000;
    for (int i = 0; i < 5; i++) k = 64'h4000_0000 - (fx_mul(z, k) + sdiv[i] / 2) / sdiv[i];
    s = fx_mul(th, k);
    k = 64'h4000_0000;
    for (int i = 0; i < 6; i++) k = 64'h4000_0000 - (fx_mul(z, k) + cdiv[i] / 2) / cdiv[i];
    c = k;
    if (swp) begin tmp = s; s = c; c = tmp; end
    case (q)
      2'd0: begin s_o = s;  c_o = c;  end
      2'd1: begin s_o = c;  c_o = -s; end
      2'd2: begin s_o = -s; c_o = -c; end
      default: begin s_o = -c; c_o = s; end
    endcase
  endfunction

  function automatic logic [15:0] q30_to_q14(longint v);
    longint unsigned m;
    m = (v < 0) ? -v : v;
    m = (m + (64'd1 << 15)) >> 16;
    if (m > 16384) m = 16384;
    if (v < 0) m = -m;
    return m[15:0];
  endfunction

  function automatic matrix_t camera_matrix(logic [15:0] ax, ay, az, logic [31:0] px, py, pz);
    longint s1, c1, s2, c2, s3, c3;
    matrix_t r;
    turn_sin_cos(ay, s1, c1);
    turn_sin_cos(ax, s2, c2);
    turn_sin_cos(az, s3, c3);
    r.ux = q30_to_q14(fx_smul(c1, c3) + fx_smul(fx_smul(s1, s2), s3));
    r.uy = q30_to_q14(fx_smul(c2, s3));
    r.uz = q30_to_q14(fx_smul(fx_smul(c1, s2), s3) - fx_smul(c3, s1));
    r.vx = q30_to_q14(fx_smul(fx_smul(c3, s1), s2) - fx_smul(c1, s3));
    r.vy = q30_to_q14(fx_smul(c2, c3));
    r.vz = q30_to_q14(fx_smul(fx_smul(c1, c3), s2) + fx_smul(s1, s3));
    r.wx = q30_to_q14(fx_smul(c2, s1));
    r.wy = q30_to_q14(-s2);
    r.wz = q30_to_q14(fx_smul(c1, c2));
    r.tx = px; r.ty = py; r.tz = pz;
    return r;
  endfunction

  // Drive one transaction, starting on a falling edge; valid drops only on idle cycles
  task automatic send_pose(logic [15:0] ax, ay, az, logic [31:0] px, py, pz);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_angle_x <= ax; in_angle_y <= ay; in_angle_z <= az;
    in_pos_x <= px; in_pos_y <= py; in_pos_z <= pz;
    matrix_queue.push_back(camera_matrix(ax, ay, az, px, py, pz));
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Receiver backpressure
  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_idle_pct);

  // Result checker
  always @(posedge clk) begin
    matrix_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_u_x, out_u_y, out_u_z, out_v_x, out_v_y, out_v_z,
             out_w_x, out_w_y, out_w_z, out_t_x, out_t_y, out_t_z};
      if (matrix_queue.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result transaction %h", got);
      end else begin
        want = matrix_queue.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("mismatch: expected %h got %h", want, got);
        end
      end
    end
  end

  task automatic test_directed();
    logic [15:0] angs[12] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h2000, 16'h2001,
                              16'h1FFF, 16'hFFFF, 16'h0001, 16'h6000, 16'hA000, 16'hE000};
    foreach (angs[i]) send_pose(angs[i], angs[(i + 3) % 12], angs[(i + 7) % 12],
                                32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
    send_pose(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000);
    send_pose(16'h0000, 16'h0000, 16'h0000, 32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    // Entries that sit exactly at plus or minus one, the clamp limit
    send_pose(16'h4000, 16'h4000, 16'h4000, 32'h1, 32'h2, 32'h3);
    send_pose(16'hC000, 16'h0000, 16'h4000, 32'h4, 32'h5, 32'h6);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++)
      send_pose(16'($urandom), 16'($urandom), 16'($urandom),
                $urandom, $urandom, $urandom);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (matrix_queue.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_idle_pct = 10; recv_idle_pct = 58;
    test_directed();
    test_random(460);
    send_idle_pct = 58; recv_idle_pct = 10;
    test_random(460);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(460);
    drain();
    if (mismatch_count == 0 && matrix_queue.size() == 0) begin
      $display("PASS euler_to_camera_matrix_unit");
    end else begin
      $display("FAIL euler_to_camera_matrix_unit");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL euler_to_camera_matrix_unit");
    $finish;
  end

endmodule
